@@ src/fmps_pkg.sv @@
package fmps_pkg;

  localparam int ADDR_WIDTH_DEF  = 12;
  localparam int TIMER_WIDTH_DEF = 14;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 14;
  localparam int SIZE_W          = 13;
  localparam int NUM_TIMERS      = 7;
  localparam int ADDR_OUT_W      = 12;
  localparam int CMP_W           = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETUP  = 3'd0,
    CFG_SHORT  = 3'd1,
    CFG_VPP    = 3'd2,
    CFG_PULSE  = 3'd3,
    CFG_PWAIT  = 3'd4,
    CFG_EPULSE = 3'd5,
    CFG_EWAIT  = 3'd6,
    CFG_SIZE   = 3'd7
  } cfg_idx_t;

  localparam logic [CFG_DATA_W-1:0] TIMER_RESET [NUM_TIMERS] = '{
    14'd50, 14'd1, 14'd100, 14'd10, 14'd100, 14'd150, 14'd10000
  };
  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd2048;

  typedef enum logic [2:0] {
    FN_TICK   = 3'd0,
    FN_READ   = 3'd1,
    FN_ERASE  = 3'd2,
    FN_PROG   = 3'd3,
    FN_FINISH = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_MISMATCH = 3'd1,
    ST_OVERSIZE = 3'd2,
    ST_REFUSED  = 3'd3,
    ST_DONE     = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_R_RESET  = 5'd1,
    PH_R_MODE   = 5'd2,
    PH_R_CLKH   = 5'd3,
    PH_R_CLKL   = 5'd4,
    PH_E_RESET  = 5'd5,
    PH_E_MODE   = 5'd6,
    PH_E_VPP    = 5'd7,
    PH_E_PULSE  = 5'd8,
    PH_E_WAIT   = 5'd9,
    PH_W_RESET  = 5'd10,
    PH_W_5V     = 5'd11,
    PH_W_DATA   = 5'd12,
    PH_W_VPP    = 5'd13,
    PH_W_PULSE  = 5'd14,
    PH_W_PWAIT  = 5'd15,
    PH_W_READ   = 5'd16,
    PH_W_TURN   = 5'd17,
    PH_W_TURN2  = 5'd18,
    PH_W_CLKH   = 5'd19,
    PH_W_CLKL   = 5'd20
  } phase_t;

  localparam logic [7:0] PB_POWER_OFF = 8'h03;
  localparam logic [7:0] PB_READ_MODE = 8'hA6;
  localparam logic [7:0] PB_WRITE_5V  = 8'hB6;
  localparam logic [7:0] PB_WRITE_12V = 8'hB4;
  localparam logic [7:0] PB_ERASE_5V  = 8'h0E;
  localparam logic [7:0] PB_ERASE_12V = 8'h0C;
  localparam logic [7:0] PB_CLOCK     = 8'h40;
  localparam logic [7:0] PB_STROBE    = 8'h04;

  typedef struct packed {
    logic [7:0] ctrl;
    logic [7:0] data;
    logic       drive;
    logic       session;
    logic [7:0] pbyte;
  } pins_t;

  typedef struct packed {
    logic          rvalid;
    logic [7:0]    rdata;
    status_t       status;
  } res_t;

endpackage

@@ src/fmps_cfg.sv @@
module fmps_cfg #(
  parameter int TIMER_WIDTH = fmps_pkg::TIMER_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [fmps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fmps_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic [TIMER_WIDTH-1:0]             ld [fmps_pkg::NUM_TIMERS],
  output logic [fmps_pkg::SIZE_W-1:0]        size
);
  import fmps_pkg::*;

  localparam int WIDE_W = CFG_DATA_W + TIMER_WIDTH + 1;
  localparam logic [WIDE_W-1:0] TMAX = WIDE_W'((64'd1 << TIMER_WIDTH) - 64'd1);

  logic [CFG_DATA_W-1:0] cfg_r [NUM_TIMERS];
  logic [SIZE_W-1:0]     size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r  <= TIMER_RESET;
      size_r <= SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SETUP, CFG_SHORT, CFG_VPP, CFG_PULSE, CFG_PWAIT, CFG_EPULSE, CFG_EWAIT: begin
          cfg_r[cfg_index] <= cfg_wdata;
        end
        CFG_SIZE: begin
          size_r <= cfg_wdata[SIZE_W-1:0];
        end
        default: begin
          size_r <= size_r;
        end
      endcase
    end
  end

  // saturate to the timer range, treat zero as one tick
  always_comb begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (cfg_r[i] == '0) begin
        ld[i] = TIMER_WIDTH'(1);
      end else if (WIDE_W'(cfg_r[i]) > TMAX) begin
        ld[i] = TMAX[TIMER_WIDTH-1:0];
      end else begin
        ld[i] = TIMER_WIDTH'(cfg_r[i]);
      end
    end
  end

  assign size = size_r;

endmodule

@@ src/fmps_step.sv @@
module fmps_step #(
  parameter int ADDR_WIDTH  = fmps_pkg::ADDR_WIDTH_DEF,
  parameter int TIMER_WIDTH = fmps_pkg::TIMER_WIDTH_DEF
) (
  input  fmps_pkg::phase_t                phase,
  input  logic [TIMER_WIDTH-1:0]          timer,
  input  logic [ADDR_WIDTH-1:0]           addr,
  input  fmps_pkg::pins_t                 pins,
  input  logic [2:0]                      func,
  input  logic [7:0]                      wbyte,
  input  logic [7:0]                      pa,
  input  logic [TIMER_WIDTH-1:0]          ld [fmps_pkg::NUM_TIMERS],
  input  logic [fmps_pkg::SIZE_W-1:0]     size,
  output fmps_pkg::phase_t                phase_nxt,
  output logic [TIMER_WIDTH-1:0]          timer_nxt,
  output logic [ADDR_WIDTH-1:0]           addr_nxt,
  output fmps_pkg::pins_t                 pins_nxt,
  output fmps_pkg::res_t                  res
);
  import fmps_pkg::*;

  logic                  is_cmd;
  logic [ADDR_WIDTH-1:0] addr_inc;
  logic [ADDR_WIDTH-1:0] prog_addr;
  logic                  at_size;
  logic                  inc_at_size;
  logic                  prog_over;

  assign is_cmd      = (func == FN_READ) || (func == FN_ERASE) ||
                       (func == FN_PROG) || (func == FN_FINISH);
  assign addr_inc    = addr + ADDR_WIDTH'(1);
  assign prog_addr   = pins.session ? addr : '0;
  assign at_size     = CMP_W'(addr) >= CMP_W'(size);
  assign inc_at_size = CMP_W'(addr_inc) >= CMP_W'(size);
  assign prog_over   = CMP_W'(prog_addr) >= CMP_W'(size);

  always_comb begin
    phase_nxt  = phase;
    timer_nxt  = timer;
    addr_nxt   = addr;
    pins_nxt   = pins;
    res.rvalid = 1'b0;
    res.rdata  = '0;
    res.status = ST_NONE;

    if (!is_cmd) begin
      if (phase != PH_IDLE) begin
        if (timer > TIMER_WIDTH'(1)) begin
          timer_nxt = timer - TIMER_WIDTH'(1);
        end else begin
          case (phase)
            PH_R_RESET: begin
              pins_nxt.ctrl = PB_READ_MODE;
              phase_nxt = PH_R_MODE;  timer_nxt = ld[CFG_SETUP];
            end
            PH_R_MODE: begin
              if (at_size) begin
                pins_nxt.ctrl = PB_POWER_OFF;
                phase_nxt = PH_IDLE;  timer_nxt = '0;  res.status = ST_DONE;
              end else begin
                res.rvalid = 1'b1;  res.rdata = pa;
                pins_nxt.ctrl = pins.ctrl | PB_CLOCK;
                phase_nxt = PH_R_CLKH;  timer_nxt = ld[CFG_PULSE];
              end
            end
            PH_R_CLKH: begin
              pins_nxt.ctrl = pins.ctrl & ~PB_CLOCK;
              phase_nxt = PH_R_CLKL;  timer_nxt = ld[CFG_PULSE];
            end
            PH_R_CLKL: begin
              addr_nxt = addr_inc;
              if (addr_inc == '0 || inc_at_size) begin
                pins_nxt.ctrl = PB_POWER_OFF;
                phase_nxt = PH_IDLE;  timer_nxt = '0;  res.status = ST_DONE;
              end else begin
                res.rvalid = 1'b1;  res.rdata = pa;
                pins_nxt.ctrl = pins.ctrl | PB_CLOCK;
                phase_nxt = PH_R_CLKH;  timer_nxt = ld[CFG_PULSE];
              end
            end
            PH_E_RESET: begin
              pins_nxt.ctrl = PB_ERASE_5V;
              phase_nxt = PH_E_MODE;  timer_nxt = ld[CFG_SETUP];
            end
            PH_E_MODE: begin
              pins_nxt.ctrl = PB_ERASE_12V;
              phase_nxt = PH_E_VPP;  timer_nxt = ld[CFG_PULSE];
            end
            PH_E_VPP: begin
              pins_nxt.ctrl = pins.ctrl & ~PB_STROBE;
              phase_nxt = PH_E_PULSE;  timer_nxt = ld[CFG_EPULSE];
            end
            PH_E_PULSE: begin
              pins_nxt.ctrl = pins.ctrl | PB_STROBE;
              phase_nxt = PH_E_WAIT;  timer_nxt = ld[CFG_EWAIT];
            end
            PH_E_WAIT: begin
              pins_nxt.ctrl = PB_POWER_OFF;
              phase_nxt = PH_IDLE;  timer_nxt = '0;  res.status = ST_DONE;
            end
            PH_W_RESET: begin
              pins_nxt.ctrl = PB_WRITE_5V;
              phase_nxt = PH_W_5V;  timer_nxt = ld[CFG_SHORT];
            end
            PH_W_5V: begin
              pins_nxt.data = pins.pbyte;  pins_nxt.drive = 1'b1;
              phase_nxt = PH_W_DATA;  timer_nxt = ld[CFG_SHORT];
            end
            PH_W_DATA: begin
              pins_nxt.ctrl = PB_WRITE_12V;
              phase_nxt = PH_W_VPP;  timer_nxt = ld[CFG_VPP];
            end
            PH_W_VPP: begin
              pins_nxt.ctrl = pins.ctrl & ~PB_STROBE;
              phase_nxt = PH_W_PULSE;  timer_nxt = ld[CFG_PULSE];
            end
            PH_W_PULSE: begin
              pins_nxt.ctrl = pins.ctrl | PB_STROBE;
              phase_nxt = PH_W_PWAIT;  timer_nxt = ld[CFG_PWAIT];
            end
            PH_W_PWAIT: begin
              pins_nxt.ctrl = PB_READ_MODE;
              phase_nxt = PH_W_READ;  timer_nxt = ld[CFG_SHORT];
            end
            PH_W_READ: begin
              pins_nxt.drive = 1'b0;
              phase_nxt = PH_W_TURN;  timer_nxt = ld[CFG_PULSE];
            end
            PH_W_TURN: begin
              if (pa != pins.pbyte) begin
                res.rvalid = 1'b1;  res.rdata = pa;
                pins_nxt.ctrl = PB_POWER_OFF;  pins_nxt.session = 1'b0;
                phase_nxt = PH_IDLE;  timer_nxt = '0;  res.status = ST_MISMATCH;
              end else begin
                pins_nxt.drive = 1'b1;
                phase_nxt = PH_W_TURN2;  timer_nxt = ld[CFG_PULSE];
              end
            end
            PH_W_TURN2: begin
              pins_nxt.ctrl = pins.ctrl | PB_CLOCK;
              phase_nxt = PH_W_CLKH;  timer_nxt = ld[CFG_PULSE];
            end
            PH_W_CLKH: begin
              pins_nxt.ctrl = pins.ctrl & ~PB_CLOCK;
              phase_nxt = PH_W_CLKL;  timer_nxt = ld[CFG_PULSE];
            end
            PH_W_CLKL: begin
              addr_nxt = addr_inc;
              phase_nxt = PH_IDLE;  timer_nxt = '0;  res.status = ST_DONE;
            end
            default: begin
              phase_nxt = PH_IDLE;  timer_nxt = '0;
            end
          endcase
        end
      end
    end else if (phase != PH_IDLE) begin
      res.status = ST_REFUSED;
    end else begin
      case (func_t'(func))
        FN_READ, FN_ERASE: begin
          pins_nxt.ctrl = '0;  pins_nxt.drive = 1'b0;  pins_nxt.session = 1'b0;
          addr_nxt = '0;
          phase_nxt = (func == FN_READ) ? PH_R_RESET : PH_E_RESET;
          timer_nxt = ld[CFG_SETUP];
        end
        FN_PROG: begin
          if (prog_over) begin
            res.status = ST_OVERSIZE;
          end else begin
            pins_nxt.pbyte = wbyte;
            if (!pins.session) begin
              pins_nxt.ctrl = '0;  pins_nxt.drive = 1'b0;  pins_nxt.session = 1'b1;
              addr_nxt = '0;
              phase_nxt = PH_W_RESET;  timer_nxt = ld[CFG_SETUP];
            end else begin
              pins_nxt.ctrl = PB_WRITE_5V;
              phase_nxt = PH_W_5V;  timer_nxt = ld[CFG_SHORT];
            end
          end
        end
        default: begin
          pins_nxt.ctrl = PB_POWER_OFF;  pins_nxt.drive = 1'b0;  pins_nxt.session = 1'b0;
          res.status = ST_DONE;
        end
      endcase
    end
  end

endmodule

@@ src/flash_mcu_programming_sequencer.sv @@
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   func, write_byte, port_a_in
// out_      output     out_valid/out_stall port_b, port_a_out, port_a_drive, busy_res,
//                                          read_valid, read_data, address, status
// cfg_      input      cfg_we              cfg_index, cfg_wdata
//
// An accepted item waits in the input register while the phase/timer update runs,
// then its result lands in the result register.
// One item per cycle while the result is not stalled.
// Synchronous active-low reset: power-off pins, idle phase, default timings.
// A stalled result holds the item in the input register; in_stall rises only then.
module flash_mcu_programming_sequencer #(
  parameter int ADDR_WIDTH  = fmps_pkg::ADDR_WIDTH_DEF,
  parameter int TIMER_WIDTH = fmps_pkg::TIMER_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [2:0]                      in_func,
  input  logic [7:0]                      in_write_byte,
  input  logic [7:0]                      in_port_a_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_port_b,
  output logic [7:0]                      out_port_a_out,
  output logic                            out_port_a_drive,
  output logic                            out_busy_res,
  output logic                            out_read_valid,
  output logic [7:0]                      out_read_data,
  output logic [fmps_pkg::ADDR_OUT_W-1:0] out_address,
  output logic [2:0]                      out_status,
  input  logic                            cfg_we,
  input  logic [fmps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fmps_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import fmps_pkg::*;

  logic [TIMER_WIDTH-1:0] ld [NUM_TIMERS];
  logic [SIZE_W-1:0]      size;

  logic       in_valid_r;
  logic [2:0] func_r;
  logic [7:0] wbyte_r;
  logic [7:0] pa_r;
  logic       adv;

  phase_t                 phase_r, phase_nxt;
  logic [TIMER_WIDTH-1:0] timer_r, timer_nxt;
  logic [ADDR_WIDTH-1:0]  addr_r, addr_nxt;
  pins_t                  pins_r, pins_nxt;
  res_t                   res;

  logic                          out_valid_r;
  logic [7:0]                    port_b_r;
  logic [7:0]                    port_a_out_r;
  logic                          port_a_drive_r;
  logic                          busy_r;
  logic                          read_valid_r;
  logic [7:0]                    read_data_r;
  logic [ADDR_OUT_W-1:0]         address_r;
  logic [2:0]                    status_r;

  fmps_cfg #(.TIMER_WIDTH(TIMER_WIDTH)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ld        (ld),
    .size      (size)
  );

  fmps_step #(.ADDR_WIDTH(ADDR_WIDTH), .TIMER_WIDTH(TIMER_WIDTH)) u_step (
    .phase     (phase_r),
    .timer     (timer_r),
    .addr      (addr_r),
    .pins      (pins_r),
    .func      (func_r),
    .wbyte     (wbyte_r),
    .pa        (pa_r),
    .ld        (ld),
    .size      (size),
    .phase_nxt (phase_nxt),
    .timer_nxt (timer_nxt),
    .addr_nxt  (addr_nxt),
    .pins_nxt  (pins_nxt),
    .res       (res)
  );

  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      func_r  <= in_func;
      wbyte_r <= in_write_byte;
      pa_r    <= in_port_a_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      timer_r <= '0;
      addr_r  <= '0;
      pins_r  <= '{ctrl: PB_POWER_OFF, data: 8'h00, drive: 1'b0, session: 1'b0,
                   pbyte: 8'h00};
    end else if (adv) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      addr_r  <= addr_nxt;
      pins_r  <= pins_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      port_b_r       <= pins_nxt.ctrl;
      port_a_out_r   <= pins_nxt.data;
      port_a_drive_r <= pins_nxt.drive;
      busy_r         <= (phase_nxt != PH_IDLE);
      read_valid_r   <= res.rvalid;
      read_data_r    <= res.rdata;
      address_r      <= ADDR_OUT_W'(addr_nxt);
      status_r       <= res.status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_port_b       = port_b_r;
  assign out_port_a_out   = port_a_out_r;
  assign out_port_a_drive = port_a_drive_r;
  assign out_busy_res     = busy_r;
  assign out_read_valid   = read_valid_r;
  assign out_read_data    = read_data_r;
  assign out_address      = address_r;
  assign out_status       = status_r;

endmodule

@@ verif/tb_flash_mcu_programming_sequencer.sv @@
module tb_flash_mcu_programming_sequencer;
  import fmps_pkg::*;

  localparam logic [2:0] FN_SPARE_LO = 3'd5;
  localparam logic [2:0] FN_SPARE_HI = 3'd7;
  localparam int unsigned WAIT_MAX = (1 << TIMER_WIDTH_DEF) - 1;
  localparam int unsigned ADDR_SPAN = 1 << ADDR_WIDTH_DEF;
  localparam int unsigned REG_MAX = (1 << CFG_DATA_W) - 1;
  localparam int unsigned SIZE_MAX = (1 << SIZE_W) - 1;
  localparam int unsigned CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [7:0]            port_b;
    logic [7:0]            a_out;
    logic                  drive;
    logic                  busy;
    logic                  rvalid;
    logic [7:0]            rdata;
    logic [ADDR_OUT_W-1:0] address;
    logic [2:0]            status;
  } pin_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_func = FN_TICK;
  logic [7:0] in_write_byte = 8'h00;
  logic [7:0] in_port_a_in = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_port_b;
  logic [7:0] out_port_a_out;
  logic out_port_a_drive;
  logic out_busy_res;
  logic out_read_valid;
  logic [7:0] out_read_data;
  logic [ADDR_OUT_W-1:0] out_address;
  logic [2:0] out_status;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SETUP;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  phase_t seq_phase = PH_IDLE;
  int unsigned seq_timer = 0;
  logic [ADDR_WIDTH_DEF-1:0] seq_addr = '0;
  logic [7:0] seq_byte = 8'h00;
  bit seq_session = 1'b0;
  logic [7:0] seq_ctrl = PB_POWER_OFF;
  logic [7:0] seq_data = 8'h00;
  bit seq_drive = 1'b0;
  int unsigned cfg_val [8];
  bit res_valid;
  logic [7:0] res_data;
  status_t res_status;

  pin_result_t pending_pins [$];
  pin_result_t want_pins;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_hold_len = 0;
  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned bytes_read = 0;
  int unsigned bytes_programmed = 0;
  int unsigned verify_errors = 0;
  int unsigned refusals = 0;
  int unsigned cycle_count = 0;

  flash_mcu_programming_sequencer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_write_byte    (in_write_byte),
    .in_port_a_in     (in_port_a_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_port_b       (out_port_b),
    .out_port_a_out   (out_port_a_out),
    .out_port_a_drive (out_port_a_drive),
    .out_busy_res     (out_busy_res),
    .out_read_valid   (out_read_valid),
    .out_read_data    (out_read_data),
    .out_address      (out_address),
    .out_status       (out_status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_flash_mcu_programming_sequencer: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rx_hold_len > 0) begin
      out_stall <= 1'b1;
      rx_hold_len = rx_hold_len - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  task automatic report_error(string msg);
    $display("ERROR: %s", msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_error($sformatf("%s got %0h, expected %0h (result %0d)",
                             name, got, want, results_checked));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pins.size() == 0) begin
        report_error("result with no item outstanding");
      end else begin
        want_pins = pending_pins.pop_front();
        check_field("port_b", out_port_b, want_pins.port_b);
        check_field("port_a_out", out_port_a_out, want_pins.a_out);
        check_field("port_a_drive", out_port_a_drive, want_pins.drive);
        check_field("busy_res", out_busy_res, want_pins.busy);
        check_field("read_valid", out_read_valid, want_pins.rvalid);
        check_field("read_data", out_read_data, want_pins.rdata);
        check_field("address", out_address, want_pins.address);
        check_field("status", out_status, want_pins.status);
        results_checked++;
      end
    end
  end

  function automatic void load_wait(phase_t ph, cfg_idx_t idx);
    int unsigned v;
    v = cfg_val[idx];
    if (v > WAIT_MAX) v = WAIT_MAX;
    if (v == 0) v = 1;
    seq_phase = ph;
    seq_timer = v;
  endfunction

  function automatic void end_sequence(status_t st);
    seq_phase = PH_IDLE;
    seq_timer = 0;
    res_status = st;
  endfunction

  function automatic int unsigned usable_size();
    return (cfg_val[CFG_SIZE] > ADDR_SPAN) ? ADDR_SPAN : cfg_val[CFG_SIZE];
  endfunction

  function automatic void clear_pins();
    seq_ctrl = 8'h00;
    seq_drive = 1'b0;
    seq_addr = '0;
    seq_session = 1'b0;
  endfunction

  function automatic void sample_or_stop(logic [7:0] pa);
    if (seq_addr >= usable_size()) begin
      seq_ctrl = PB_POWER_OFF;
      end_sequence(ST_DONE);
    end else begin
      res_valid = 1'b1;
      res_data = pa;
      seq_ctrl |= PB_CLOCK;
      load_wait(PH_R_CLKH, CFG_PULSE);
      bytes_read++;
    end
  endfunction

  function automatic void expire_phase(logic [7:0] pa);
    case (seq_phase)
      PH_R_RESET: begin
        seq_ctrl = PB_READ_MODE;
        load_wait(PH_R_MODE, CFG_SETUP);
      end
      PH_R_MODE: sample_or_stop(pa);
      PH_R_CLKH: begin
        seq_ctrl &= ~PB_CLOCK;
        load_wait(PH_R_CLKL, CFG_PULSE);
      end
      PH_R_CLKL: begin
        seq_addr++;
        if (seq_addr == 0) begin
          seq_ctrl = PB_POWER_OFF;
          end_sequence(ST_DONE);
        end else begin
          sample_or_stop(pa);
        end
      end
      PH_E_RESET: begin
        seq_ctrl = PB_ERASE_5V;
        load_wait(PH_E_MODE, CFG_SETUP);
      end
      PH_E_MODE: begin
        seq_ctrl = PB_ERASE_12V;
        load_wait(PH_E_VPP, CFG_PULSE);
      end
      PH_E_VPP: begin
        seq_ctrl &= ~PB_STROBE;
        load_wait(PH_E_PULSE, CFG_EPULSE);
      end
      PH_E_PULSE: begin
        seq_ctrl |= PB_STROBE;
        load_wait(PH_E_WAIT, CFG_EWAIT);
      end
      PH_E_WAIT: begin
        seq_ctrl = PB_POWER_OFF;
        end_sequence(ST_DONE);
      end
      PH_W_RESET: begin
        seq_ctrl = PB_WRITE_5V;
        load_wait(PH_W_5V, CFG_SHORT);
      end
      PH_W_5V: begin
        seq_data = seq_byte;
        seq_drive = 1'b1;
        load_wait(PH_W_DATA, CFG_SHORT);
      end
      PH_W_DATA: begin
        seq_ctrl = PB_WRITE_12V;
        load_wait(PH_W_VPP, CFG_VPP);
      end
      PH_W_VPP: begin
        seq_ctrl &= ~PB_STROBE;
        load_wait(PH_W_PULSE, CFG_PULSE);
      end
      PH_W_PULSE: begin
        seq_ctrl |= PB_STROBE;
        load_wait(PH_W_PWAIT, CFG_PWAIT);
      end
      PH_W_PWAIT: begin
        seq_ctrl = PB_READ_MODE;
        load_wait(PH_W_READ, CFG_SHORT);
      end
      PH_W_READ: begin
        seq_drive = 1'b0;
        load_wait(PH_W_TURN, CFG_PULSE);
      end
      PH_W_TURN: begin
        if (pa != seq_byte) begin
          res_valid = 1'b1;
          res_data = pa;
          seq_ctrl = PB_POWER_OFF;
          seq_session = 1'b0;
          end_sequence(ST_MISMATCH);
          verify_errors++;
        end else begin
          seq_drive = 1'b1;
          load_wait(PH_W_TURN2, CFG_PULSE);
        end
      end
      PH_W_TURN2: begin
        seq_ctrl |= PB_CLOCK;
        load_wait(PH_W_CLKH, CFG_PULSE);
      end
      PH_W_CLKH: begin
        seq_ctrl &= ~PB_CLOCK;
        load_wait(PH_W_CLKL, CFG_PULSE);
      end
      PH_W_CLKL: begin
        seq_addr++;
        end_sequence(ST_DONE);
        bytes_programmed++;
      end
      default: end_sequence(ST_NONE);
    endcase
  endfunction

  function automatic pin_result_t predict_pins(logic [2:0] f, logic [7:0] wb,
                                               logic [7:0] pa);
    pin_result_t r;
    int unsigned a;
    res_valid = 1'b0;
    res_data = 8'h00;
    res_status = ST_NONE;
    if (f == FN_TICK || f > FN_FINISH) begin
      if (seq_phase != PH_IDLE) begin
        if (seq_timer > 1) seq_timer--;
        else expire_phase(pa);
      end
    end else if (seq_phase != PH_IDLE) begin
      res_status = ST_REFUSED;
      refusals++;
    end else begin
      case (f)
        FN_READ: begin
          clear_pins();
          load_wait(PH_R_RESET, CFG_SETUP);
        end
        FN_ERASE: begin
          clear_pins();
          load_wait(PH_E_RESET, CFG_SETUP);
        end
        FN_PROG: begin
          a = seq_session ? seq_addr : 0;
          if (a >= usable_size()) begin
            res_status = ST_OVERSIZE;
          end else begin
            seq_byte = wb;
            if (!seq_session) begin
              clear_pins();
              seq_session = 1'b1;
              load_wait(PH_W_RESET, CFG_SETUP);
            end else begin
              seq_ctrl = PB_WRITE_5V;
              load_wait(PH_W_5V, CFG_SHORT);
            end
          end
        end
        default: begin
          seq_ctrl = PB_POWER_OFF;
          seq_drive = 1'b0;
          seq_session = 1'b0;
          res_status = ST_DONE;
        end
      endcase
    end
    r.port_b = seq_ctrl;
    r.a_out = seq_data;
    r.drive = seq_drive;
    r.busy = (seq_phase != PH_IDLE);
    r.rvalid = res_valid;
    r.rdata = res_data;
    r.address = seq_addr;
    r.status = res_status;
    return r;
  endfunction

  task automatic send_item(logic [2:0] f, logic [7:0] wb, logic [7:0] pa);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_write_byte <= wb;
    in_port_a_in <= pa;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_pins = {pending_pins, predict_pins(f, wb, pa)};
    items_sent++;
  endtask

  task automatic tick_to_idle(bit spoil);
    logic [7:0] pa;
    while (seq_phase != PH_IDLE) begin
      pa = $urandom;
      if (seq_phase == PH_W_TURN) pa = spoil ? ~seq_byte : seq_byte;
      send_item(FN_TICK, $urandom, pa);
    end
  endtask

  task automatic settle();
    tick_to_idle(1'b0);
    in_valid <= 1'b0;
    while (pending_pins.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_timing(int unsigned w_setup, int unsigned w_short,
                              int unsigned w_vpp, int unsigned w_pulse,
                              int unsigned w_pwait, int unsigned w_epulse,
                              int unsigned w_ewait, int unsigned dev_size);
    int unsigned vals [8];
    int i;
    vals = '{w_setup, w_short, w_vpp, w_pulse, w_pwait, w_epulse, w_ewait, dev_size};
    settle();
    for (i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_wdata <= vals[i][CFG_DATA_W-1:0];
      @(posedge clk);
      cfg_we <= 1'b0;
      cfg_val[i] = vals[i] & ((cfg_idx_t'(i) == CFG_SIZE) ? SIZE_MAX : REG_MAX);
      @(posedge clk);
    end
  endtask

  function automatic int unsigned rand_wait();
    return ($urandom_range(7) == 0) ? $urandom_range(24) : $urandom_range(3);
  endfunction

  task automatic rand_item();
    int unsigned r;
    logic [2:0] f;
    logic [7:0] pa;
    r = $urandom_range(99);
    pa = $urandom;
    if (seq_phase == PH_IDLE) begin
      if (r < 15) f = FN_READ;
      else if (r < 25) f = FN_ERASE;
      else if (r < 70) f = FN_PROG;
      else if (r < 82) f = FN_FINISH;
      else if (r < 92) f = FN_TICK;
      else f = $urandom_range(FN_SPARE_LO, FN_SPARE_HI);
    end else begin
      if (r < 88) f = FN_TICK;
      else if (r < 94) f = $urandom_range(FN_SPARE_LO, FN_SPARE_HI);
      else f = $urandom_range(FN_READ, FN_FINISH);
      if (seq_phase == PH_W_TURN && $urandom_range(99) < 85) pa = seq_byte;
    end
    send_item(f, $urandom, pa);
  endtask

  task automatic test_defaults();
    int c;
    send_item(FN_FINISH, 8'h00, 8'h00);
    send_item(FN_TICK, 8'hFF, 8'hFF);
    for (c = FN_SPARE_LO; c <= FN_SPARE_HI; c++) send_item(c[2:0], $urandom, $urandom);
    send_item(FN_PROG, 8'hFF, 8'h00);
    repeat (3) send_item(FN_TICK, $urandom, $urandom);
    for (c = FN_READ; c <= FN_FINISH; c++) send_item(c[2:0], $urandom, $urandom);
    tick_to_idle(1'b0);
    send_item(FN_FINISH, 8'h00, 8'h00);
  endtask

  task automatic test_read();
    apply_timing(1, 1, 1, 2, 1, 1, 1, 3);
    send_item(FN_READ, $urandom, $urandom);
    repeat (4) send_item(FN_TICK, $urandom, $urandom);
    send_item(FN_READ, $urandom, $urandom);
    tick_to_idle(1'b0);
    // zero waits act as one tick; zero size reads nothing
    apply_timing(0, 0, 0, 0, 0, 0, 0, 0);
    send_item(FN_READ, $urandom, $urandom);
    tick_to_idle(1'b0);
    // size above the address range clamps
    apply_timing(1, 1, 1, 1, 1, 1, 1, 8191);
    send_item(FN_PROG, $urandom, $urandom);
    tick_to_idle(1'b0);
    send_item(FN_FINISH, $urandom, $urandom);
  endtask

  task automatic test_erase();
    apply_timing(2, 1, 1, 3, 1, 4, 5, 16);
    send_item(FN_ERASE, $urandom, $urandom);
    send_item(FN_PROG, $urandom, $urandom);
    tick_to_idle(1'b0);
  endtask

  task automatic test_program();
    apply_timing(1, 0, 2, 1, 1, 1, 1, 3);
    send_item(FN_PROG, 8'hA5, $urandom);
    tick_to_idle(1'b0);
    send_item(FN_PROG, 8'h5A, $urandom);
    tick_to_idle(1'b0);
    send_item(FN_PROG, 8'h00, $urandom);
    tick_to_idle(1'b0);
    send_item(FN_PROG, 8'hFF, $urandom);
    send_item(FN_FINISH, $urandom, $urandom);
    // verify mismatch closes the session
    send_item(FN_PROG, 8'h3C, $urandom);
    tick_to_idle(1'b1);
    send_item(FN_PROG, 8'hC3, $urandom);
    tick_to_idle(1'b0);
    send_item(FN_READ, $urandom, $urandom);
    tick_to_idle(1'b0);
    send_item(FN_PROG, 8'h11, $urandom);
    tick_to_idle(1'b0);
    send_item(FN_ERASE, $urandom, $urandom);
    tick_to_idle(1'b0);
    send_item(FN_PROG, 8'h22, $urandom);
    tick_to_idle(1'b0);
    send_item(FN_FINISH, $urandom, $urandom);
    send_item(FN_FINISH, $urandom, $urandom);
    apply_timing(1, 1, 1, 1, 1, 1, 1, 0);
    send_item(FN_PROG, 8'h77, $urandom);
  endtask

  task automatic test_backpressure();
    apply_timing(rand_wait(), rand_wait(), rand_wait(), rand_wait(),
                 rand_wait(), rand_wait(), rand_wait(), $urandom_range(8));
    rx_hold_len = 300;
    repeat (60) rand_item();
    settle();
  endtask

  task automatic test_random_traffic(int unsigned tx_pct, int unsigned rx_pct, int n);
    int k;
    apply_timing(rand_wait(), rand_wait(), rand_wait(), rand_wait(),
                 rand_wait(), rand_wait(), rand_wait(), $urandom_range(8));
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    for (k = 0; k < n; k++) rand_item();
    settle();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
  endtask

  initial begin
    int i;
    for (i = 0; i < NUM_TIMERS; i++) cfg_val[i] = TIMER_RESET[i];
    cfg_val[CFG_SIZE] = SIZE_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_read();
    test_erase();
    test_program();
    test_backpressure();
    test_random_traffic(0, 0, 80);
    test_random_traffic(84, 0, 80);
    test_random_traffic(0, 84, 80);
    test_random_traffic(23, 23, 80);
    settle();
    repeat (8) @(posedge clk);
    $display("Covered %0d items, %0d results: %0d bytes read, %0d programmed, %0d verify errors",
             items_sent, results_checked, bytes_read, bytes_programmed, verify_errors);
    $display("Also %0d refused commands, zero and oversize timing, a long hold, four idle mixes",
             refusals);
    if (error_count == 0) begin
      $display("tb_flash_mcu_programming_sequencer: done, clean");
    end else begin
      $display("tb_flash_mcu_programming_sequencer: done, errors");
    end
    $finish;
  end

endmodule
